### rtl/core/gmg_pkg.sv
package gmg_pkg;

  localparam logic [1:0] MODE_LINEAR  = 2'd0;
  localparam logic [1:0] MODE_RADIAL  = 2'd1;
  localparam logic [1:0] MODE_REFLECT = 2'd2;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_X = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_X   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_Y   = 3'd4;

  localparam int LEVEL_BITS = 8;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = 8'd0;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;

  typedef struct packed {
    logic valid;
    logic bypass;
  } gmg_ctl_t;

endpackage

### rtl/core/gmg_front.sv
module gmg_front #(
  parameter int COORD_BITS = 15,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW,
  localparam int SW = PW + 1,
  localparam int LW = 2 * COORD_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [1:0]                   mode,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] pixel_x,
  input  logic signed [COORD_BITS-1:0] pixel_y,
  output gmg_pkg::gmg_ctl_t            ctl_o,
  output logic [1:0]                   mode_o,
  output logic signed [SW-1:0]         n_o,
  output logic [LW-1:0]                l2_o
);

  // stage 1: offsets
  logic                 v1_r;
  logic [1:0]           mode1_r;
  logic signed [DW-1:0] qx1_r, qy1_r, dx1_r, dy1_r;
  logic signed [DW-1:0] qx_nxt, qy_nxt, dx_nxt, dy_nxt;

  // stage 2: products
  logic                 v2_r;
  logic [1:0]           mode2_r;
  logic signed [PW-1:0] pa2_r, pb2_r, sa2_r, sb2_r;
  logic signed [DW-1:0] ax, ay;

  // stage 3: sums
  logic                 v3_r;
  logic [1:0]           mode3_r;
  logic signed [SW-1:0] n3_r;
  logic [LW-1:0]        l23_r;
  logic signed [SW-1:0] n_nxt, l2_full;

  assign qx_nxt = DW'(pixel_x) - DW'(start_x);
  assign qy_nxt = DW'(pixel_y) - DW'(start_y);
  assign dx_nxt = DW'(end_x) - DW'(start_x);
  assign dy_nxt = DW'(end_y) - DW'(start_y);

  // radial squares the offset, the others project it on the axis
  assign ax = (mode1_r == gmg_pkg::MODE_RADIAL) ? qx1_r : dx1_r;
  assign ay = (mode1_r == gmg_pkg::MODE_RADIAL) ? qy1_r : dy1_r;

  assign n_nxt   = SW'(pa2_r) + SW'(pb2_r);
  assign l2_full = SW'(sa2_r) + SW'(sb2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r <= mode;
      qx1_r   <= qx_nxt;
      qy1_r   <= qy_nxt;
      dx1_r   <= dx_nxt;
      dy1_r   <= dy_nxt;
      mode2_r <= mode1_r;
      pa2_r   <= qx1_r * ax;
      pb2_r   <= qy1_r * ay;
      sa2_r   <= dx1_r * dx1_r;
      sb2_r   <= dy1_r * dy1_r;
      mode3_r <= mode2_r;
      n3_r    <= n_nxt;
      l23_r   <= l2_full[LW-1:0];
    end
  end

  assign ctl_o.valid  = v3_r;
  assign ctl_o.bypass = 1'b0;
  assign mode_o       = mode3_r;
  assign n_o          = n3_r;
  assign l2_o         = l23_r;

endmodule

### rtl/core/gmg_classify.sv
module gmg_classify #(
  parameter int COORD_BITS = 15,
  localparam int SW = 2 * (COORD_BITS + 1) + 1,
  localparam int TW = SW + 1,
  localparam int LW = 2 * COORD_BITS + 1,
  localparam int RW = LW + gmg_pkg::LEVEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  gmg_pkg::gmg_ctl_t                 ctl_i,
  input  logic [1:0]                        mode,
  input  logic signed [SW-1:0]              n,
  input  logic [LW-1:0]                     l2,
  output gmg_pkg::gmg_ctl_t                 ctl_o,
  output logic [gmg_pkg::LEVEL_BITS-1:0]    level_o,
  output logic [RW-1:0]                     rem_o,
  output logic [LW-1:0]                     den_o
);

  logic signed [SW-1:0] l2s;
  logic signed [TW-1:0] t, tmag;
  logic signed [SW-1:0] diff;
  logic                 bypass_nxt;
  logic [gmg_pkg::LEVEL_BITS-1:0] level_nxt;
  logic [LW-1:0]        num_nxt;

  gmg_pkg::gmg_ctl_t              ctl4_r;
  logic [gmg_pkg::LEVEL_BITS-1:0] level4_r;
  logic [LW-1:0]                  num4_r, den4_r;

  gmg_pkg::gmg_ctl_t              ctl5_r;
  logic [gmg_pkg::LEVEL_BITS-1:0] level5_r;
  logic [RW-1:0]                  rem5_r;
  logic [LW-1:0]                  den5_r;

  assign l2s  = $signed(SW'(l2));
  assign diff = l2s - n;
  assign t    = TW'(l2s) - TW'(n) - TW'(n);
  assign tmag = (t < 0) ? -t : t;

  always_comb begin
    bypass_nxt = 1'b1;
    level_nxt  = gmg_pkg::LEVEL_MIN;
    num_nxt    = diff[LW-1:0];
    if (l2 != '0) begin
      case (mode)
        gmg_pkg::MODE_LINEAR: begin
          if (n <= 0) begin
            level_nxt = gmg_pkg::LEVEL_MAX;
          end else if (n < l2s) begin
            bypass_nxt = 1'b0;
          end
        end
        gmg_pkg::MODE_RADIAL: begin
          if (n < l2s) begin
            bypass_nxt = 1'b0;
          end
        end
        gmg_pkg::MODE_REFLECT: begin
          num_nxt = tmag[LW-1:0];
          if (tmag >= TW'(l2s)) begin
            level_nxt = gmg_pkg::LEVEL_MAX;
          end else begin
            bypass_nxt = 1'b0;
          end
        end
        default: begin
          level_nxt = gmg_pkg::LEVEL_MIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (adv) begin
      ctl4_r.valid  <= ctl_i.valid;
      ctl4_r.bypass <= bypass_nxt;
      ctl5_r        <= ctl4_r;
    end
  end

  // 255 * num as a shift and subtract
  always_ff @(posedge clk) begin
    if (adv) begin
      level4_r <= level_nxt;
      num4_r   <= num_nxt;
      den4_r   <= l2;
      level5_r <= level4_r;
      rem5_r   <= (RW'(num4_r) << gmg_pkg::LEVEL_BITS) - RW'(num4_r);
      den5_r   <= den4_r;
    end
  end

  assign ctl_o   = ctl5_r;
  assign level_o = level5_r;
  assign rem_o   = rem5_r;
  assign den_o   = den5_r;

endmodule

### rtl/core/gmg_div_step.sv
module gmg_div_step #(
  parameter int LW    = 31,
  parameter int SHIFT = 7,
  localparam int RW   = LW + gmg_pkg::LEVEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  gmg_pkg::gmg_ctl_t              ctl_i,
  input  logic [gmg_pkg::LEVEL_BITS-1:0] level_i,
  input  logic [RW-1:0]                  rem_i,
  input  logic [LW-1:0]                  den_i,
  output gmg_pkg::gmg_ctl_t              ctl_o,
  output logic [gmg_pkg::LEVEL_BITS-1:0] level_o,
  output logic [RW-1:0]                  rem_o,
  output logic [LW-1:0]                  den_o
);

  logic [RW-1:0] dsh;
  logic          take;

  gmg_pkg::gmg_ctl_t              ctl_r;
  logic [gmg_pkg::LEVEL_BITS-1:0] level_r, level_nxt;
  logic [RW-1:0]                  rem_r, rem_nxt;
  logic [LW-1:0]                  den_r;

  assign dsh  = RW'(den_i) << SHIFT;
  assign take = !ctl_i.bypass && (rem_i >= dsh);

  always_comb begin
    level_nxt = level_i;
    rem_nxt   = rem_i;
    if (take) begin
      level_nxt[SHIFT] = 1'b1;
      rem_nxt          = rem_i - dsh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      level_r <= level_nxt;
      rem_r   <= rem_nxt;
      den_r   <= den_i;
    end
  end

  assign ctl_o   = ctl_r;
  assign level_o = level_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;

endmodule

### rtl/core/gradient_mask_generator.sv
// Gradient mask generator: one pixel coordinate in, one 8-bit level out.
// Input channel in_valid/in_ready carries in_pixel_x, in_pixel_y; result
// channel out_valid/out_ready carries out_level. Both move one beat per
// handshake.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is
// high (0 mode, 1 start_x, 2 start_y, 3 end_x, 4 end_y). Write only while
// no pixel is in flight.
// From input beat to result valid, three stages form
// the offsets, products and sums, two classify and scale, and eight
// restoring-division stages produce one quotient bit each.
// Throughput is one pixel per cycle while the receiver does not stall; every stage is fully pipelined.
// Reset clears the configuration registers to zero and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// while a result is waiting; nothing is lost or repeated.
module gradient_mask_generator #(
  parameter int COORD_BITS = 15
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [gmg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                  cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_BITS-1:0]           in_pixel_x,
  input  logic signed [COORD_BITS-1:0]           in_pixel_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [gmg_pkg::LEVEL_BITS-1:0]         out_level
);

  localparam int SW    = 2 * (COORD_BITS + 1) + 1;
  localparam int LW    = 2 * COORD_BITS + 1;
  localparam int RW    = LW + gmg_pkg::LEVEL_BITS;
  localparam int STEPS = gmg_pkg::LEVEL_BITS;

  logic [1:0]                   mode_r;
  logic signed [COORD_BITS-1:0] start_x_r, start_y_r, end_x_r, end_y_r;

  logic adv;

  gmg_pkg::gmg_ctl_t    f_ctl;
  logic [1:0]           f_mode;
  logic signed [SW-1:0] f_n;
  logic [LW-1:0]        f_l2;

  gmg_pkg::gmg_ctl_t              d_ctl   [STEPS+1];
  logic [gmg_pkg::LEVEL_BITS-1:0] d_level [STEPS+1];
  logic [RW-1:0]                  d_rem   [STEPS+1];
  logic [LW-1:0]                  d_den   [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gmg_pkg::REG_MODE:    mode_r    <= cfg_wdata[1:0];
        gmg_pkg::REG_START_X: start_x_r <= $signed(cfg_wdata);
        gmg_pkg::REG_START_Y: start_y_r <= $signed(cfg_wdata);
        gmg_pkg::REG_END_X:   end_x_r   <= $signed(cfg_wdata);
        gmg_pkg::REG_END_Y:   end_y_r   <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  assign adv      = !d_ctl[STEPS].valid || out_ready;
  assign in_ready = adv;

  gmg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .mode     (mode_r),
    .start_x  (start_x_r),
    .start_y  (start_y_r),
    .end_x    (end_x_r),
    .end_y    (end_y_r),
    .pixel_x  (in_pixel_x),
    .pixel_y  (in_pixel_y),
    .ctl_o    (f_ctl),
    .mode_o   (f_mode),
    .n_o      (f_n),
    .l2_o     (f_l2)
  );

  gmg_classify #(
    .COORD_BITS(COORD_BITS)
  ) u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_i   (f_ctl),
    .mode    (f_mode),
    .n       (f_n),
    .l2      (f_l2),
    .ctl_o   (d_ctl[0]),
    .level_o (d_level[0]),
    .rem_o   (d_rem[0]),
    .den_o   (d_den[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_div
    gmg_div_step #(
      .LW    (LW),
      .SHIFT (STEPS - 1 - i)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .ctl_i   (d_ctl[i]),
      .level_i (d_level[i]),
      .rem_i   (d_rem[i]),
      .den_i   (d_den[i]),
      .ctl_o   (d_ctl[i+1]),
      .level_o (d_level[i+1]),
      .rem_o   (d_rem[i+1]),
      .den_o   (d_den[i+1])
    );
  end

  assign out_valid = d_ctl[STEPS].valid;
  assign out_level = d_level[STEPS];

endmodule

### verif/gradient_mask_generator_tb.sv
module gradient_mask_generator_tb;

  localparam int CW = 15;
  localparam int C_LO = -(2 ** (CW - 1));
  localparam int C_HI = 2 ** (CW - 1) - 1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int NO_TYPED = -1;
  localparam int PHASES = 16;
  localparam int PIXELS_PER_PHASE = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_DEPTH = 13;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [gmg_pkg::LEVEL_BITS-1:0] level_t;

  typedef struct {
    logic [1:0] mode;
    coord_t sx, sy, ex, ey, px, py;
    int level;
  } grad_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gmg_pkg::CFG_INDEX_BITS-1:0] cfg_index = gmg_pkg::REG_MODE;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_pixel_x = '0;
  coord_t in_pixel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  level_t out_level;

  // typed expectation travels with the beat; NO_TYPED means use the predictor
  int typed_level = NO_TYPED;

  logic [1:0] mode_r = gmg_pkg::MODE_LINEAR;
  coord_t start_x_r = '0, start_y_r = '0, end_x_r = '0, end_y_r = '0;

  level_t level_q[$];
  int send_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int pixels_sent = 0;
  int levels_checked = 0;
  int setups = 0;
  int quiet_cycles = 0;

  grad_row_t dir_rows [25] = '{
    // reset setup: zero-length gradient
    '{gmg_pkg::MODE_LINEAR,  0, 0, 0, 0, 0, 0, 0},
    '{gmg_pkg::MODE_LINEAR,  0, 0, 0, 0, 16383, -16384, 0},
    '{gmg_pkg::MODE_LINEAR,  0, 0, 100, 0, 0, 0, 255},
    '{gmg_pkg::MODE_LINEAR,  0, 0, 100, 0, 100, 0, 0},
    '{gmg_pkg::MODE_LINEAR,  0, 0, 100, 0, -50, 7, 255},
    '{gmg_pkg::MODE_LINEAR,  0, 0, 100, 0, 200, -3, 0},
    '{gmg_pkg::MODE_LINEAR,  0, 0, 100, 0, 50, 0, NO_TYPED},
    '{gmg_pkg::MODE_RADIAL,  0, 0, 100, 0, 0, 0, 255},
    '{gmg_pkg::MODE_RADIAL,  0, 0, 100, 0, 0, 100, 0},
    '{gmg_pkg::MODE_RADIAL,  0, 0, 100, 0, 30, 40, NO_TYPED},
    '{gmg_pkg::MODE_REFLECT, 0, 0, 100, 0, 0, 0, 255},
    '{gmg_pkg::MODE_REFLECT, 0, 0, 100, 0, 100, 0, 255},
    '{gmg_pkg::MODE_REFLECT, 0, 0, 100, 0, 50, 0, 0},
    '{gmg_pkg::MODE_REFLECT, 0, 0, 100, 0, 25, 0, NO_TYPED},
    '{gmg_pkg::MODE_REFLECT, 0, 0, 100, 0, -100, 0, 255},
    '{MODE_UNUSED,           0, 0, 100, 0, 50, 0, 0},
    // start equals end
    '{gmg_pkg::MODE_LINEAR,  16383, -16384, 16383, -16384, 5, 5, 0},
    '{gmg_pkg::MODE_RADIAL,  16383, -16384, 16383, -16384, 16383, -16384, 0},
    '{gmg_pkg::MODE_REFLECT, 16383, -16384, 16383, -16384, -16384, 16383, 0},
    // full-range diagonal
    '{gmg_pkg::MODE_LINEAR,  -16384, -16384, 16383, 16383, 16383, -16384, NO_TYPED},
    '{gmg_pkg::MODE_LINEAR,  -16384, -16384, 16383, 16383, -16384, -16384, 255},
    '{gmg_pkg::MODE_LINEAR,  -16384, -16384, 16383, 16383, 16383, 16383, 0},
    '{gmg_pkg::MODE_RADIAL,  -16384, -16384, 16383, 16383, 16383, -16384, NO_TYPED},
    '{gmg_pkg::MODE_REFLECT, -16384, -16384, 16383, 16383, 16383, 16383, 255},
    '{gmg_pkg::MODE_REFLECT, -16384, -16384, 16383, 16383, 0, 0, NO_TYPED}
  };

  gradient_mask_generator #(.COORD_BITS(CW)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_level  (out_level)
  );

  always #2 clk = ~clk;

  function automatic level_t gradient_level(
    logic [1:0] m, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
    coord_t px, coord_t py);
    longint dx, dy, qx, qy, len2, proj, t;
    level_t lvl;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    qx = longint'(px) - longint'(sx);
    qy = longint'(py) - longint'(sy);
    len2 = dx * dx + dy * dy;
    lvl = gmg_pkg::LEVEL_MIN;
    if (len2 > 0) begin
      case (m)
        gmg_pkg::MODE_LINEAR: begin
          proj = qx * dx + qy * dy;
          if (proj <= 0) lvl = gmg_pkg::LEVEL_MAX;
          else if (proj >= len2) lvl = gmg_pkg::LEVEL_MIN;
          else lvl = level_t'((len2 - proj) * 255 / len2);
        end
        gmg_pkg::MODE_RADIAL: begin
          proj = qx * qx + qy * qy;
          if (proj >= len2) lvl = gmg_pkg::LEVEL_MIN;
          else lvl = level_t'((len2 - proj) * 255 / len2);
        end
        gmg_pkg::MODE_REFLECT: begin
          proj = qx * dx + qy * dy;
          t = len2 - 2 * proj;
          if (t < 0) t = -t;
          if (t >= len2) lvl = gmg_pkg::LEVEL_MAX;
          else lvl = level_t'(t * 255 / len2);
        end
        default: lvl = gmg_pkg::LEVEL_MIN;
      endcase
    end
    return lvl;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : level_check
    level_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        moved = 1'b1;
        pixels_sent++;
        if (typed_level >= 0) want = level_t'(typed_level);
        else want = gradient_level(mode_r, start_x_r, start_y_r, end_x_r, end_y_r,
                                   in_pixel_x, in_pixel_y);
        level_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (level_q.size() == 0) begin
          errors++;
          $error("unexpected beat: level actual %0d", out_level);
        end else begin
          want = level_q.pop_front();
          levels_checked++;
          if (out_level !== want) begin
            errors++;
            $error("level: expected %0d, actual %0d", want, out_level);
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d levels outstanding", level_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (level_q.size() != 0);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gmg_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [CW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      gmg_pkg::REG_MODE:    mode_r = data[1:0];
      gmg_pkg::REG_START_X: start_x_r = data;
      gmg_pkg::REG_START_Y: start_y_r = data;
      gmg_pkg::REG_END_X:   end_x_r = data;
      gmg_pkg::REG_END_Y:   end_y_r = data;
      default: ;
    endcase
  endtask

  task automatic program_gradient(input logic [1:0] m, input coord_t sx, input coord_t sy,
                                  input coord_t ex, input coord_t ey);
    wait_drained();
    // junk in the upper mode bits must be ignored
    write_reg(gmg_pkg::REG_MODE, {(CW-2)'($urandom), m});
    write_reg(gmg_pkg::REG_START_X, sx);
    write_reg(gmg_pkg::REG_START_Y, sy);
    write_reg(gmg_pkg::REG_END_X, ex);
    write_reg(gmg_pkg::REG_END_Y, ey);
    cfg_we <= 1'b0;
    @(posedge clk);
    setups++;
  endtask

  task automatic send_pixel(input coord_t px, input coord_t py, input int lvl);
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    typed_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pick_gradient(input int kind, output coord_t sx, output coord_t sy,
                               output coord_t ex, output coord_t ey);
    int cx, cy, off;
    case (kind)
      0: begin
        sx = coord_t'($urandom); sy = coord_t'($urandom);
        ex = coord_t'($urandom); ey = coord_t'($urandom);
      end
      1: begin
        cx = int'($urandom_range(0, 30000)) - 15000;
        cy = int'($urandom_range(0, 30000)) - 15000;
        sx = coord_t'(cx + int'($urandom_range(0, 600)) - 300);
        sy = coord_t'(cy + int'($urandom_range(0, 600)) - 300);
        ex = coord_t'(cx + int'($urandom_range(0, 600)) - 300);
        ey = coord_t'(cy + int'($urandom_range(0, 600)) - 300);
      end
      2: begin
        sx = coord_t'($urandom_range(0, 1) ? C_HI : C_LO);
        sy = coord_t'($urandom_range(0, 1) ? C_HI : C_LO);
        ex = coord_t'($urandom_range(0, 1) ? C_HI : C_LO);
        ey = coord_t'($urandom_range(0, 1) ? C_HI : C_LO);
      end
      default: begin
        // short axis-aligned gradients
        sx = coord_t'($urandom); sy = coord_t'($urandom);
        off = int'($urandom_range(1, 3));
        if ($urandom_range(0, 1)) begin
          ex = coord_t'(sx + off); ey = sy;
        end else begin
          ex = sx; ey = coord_t'(sy - off);
        end
      end
    endcase
  endtask

  task automatic pick_pixel(output coord_t px, output coord_t py);
    int dx, dy, k, j, r;
    dx = int'(end_x_r) - int'(start_x_r);
    dy = int'(end_y_r) - int'(start_y_r);
    r = int'($urandom_range(0, 9));
    if (r < 3) begin
      px = coord_t'($urandom);
      py = coord_t'($urandom);
    end else if (r < 9) begin
      // around the segment, in units of 1/64 of its length
      k = int'($urandom_range(0, 96)) - 16;
      j = int'($urandom_range(0, 80)) - 40;
      px = coord_t'(int'(start_x_r) + (dx * k - dy * j) / 64);
      py = coord_t'(int'(start_y_r) + (dy * k + dx * j) / 64);
    end else if ($urandom_range(0, 1)) begin
      px = start_x_r; py = start_y_r;
    end else begin
      px = end_x_r; py = end_y_r;
    end
  endtask

  initial begin : stimulus
    coord_t sx, sy, ex, ey, px, py;
    logic [1:0] m;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_r || dir_rows[i].sx != start_x_r ||
          dir_rows[i].sy != start_y_r || dir_rows[i].ex != end_x_r ||
          dir_rows[i].ey != end_y_r)
        program_gradient(dir_rows[i].mode, dir_rows[i].sx, dir_rows[i].sy,
                         dir_rows[i].ex, dir_rows[i].ey);
      send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].level);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0: m = gmg_pkg::MODE_LINEAR;
        1: m = gmg_pkg::MODE_RADIAL;
        default: m = gmg_pkg::MODE_REFLECT;
      endcase
      if (p == 13) m = MODE_UNUSED;
      pick_gradient((p + p / 4) % 4, sx, sy, ex, ey);
      program_gradient(m, sx, sy, ex, ey);
      case (p % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 73; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 73; end
        default: begin send_pct = 24; stall_pct = 24; end
      endcase
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        pick_pixel(px, py);
        send_pixel(px, py, NO_TYPED);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (level_q.size() != 0);
    repeat (PIPE_DEPTH + 7) @(posedge clk);

    $display("%0d pixels sent, %0d levels checked across %0d gradient setups", pixels_sent,
             levels_checked, setups);
    $display("modes linear/radial/reflected/unused, extreme and degenerate endpoints, idle+stall");
    if (errors == 0 && level_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (level_q.size() != 0) $error("%0d expected levels never arrived", level_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
